/* rtl/rpa_pkg.sv */
// ----------------------------------------------------------------------------
// rpa_pkg - shared types and constants of the range port allocator
//
// Field widths, item modes, result status codes and the controller states.
// ----------------------------------------------------------------------------
package rpa_pkg;

  // Payload field widths
  localparam int PORT_W   = 16;
  localparam int COUNT_W  = 7;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 11;

  // Bitmap row width and smallest usable span
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int MIN_SPAN = 8;

  // Stream packing
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SKIP  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_LOAD,
    S_SCAN
  } rpa_state_e;

endpackage

/* rtl/range_port_allocator.sv */
// ----------------------------------------------------------------------------
// range_port_allocator - lowest-first port allocator over a configured range
//
// Keeps a used/free bitmap in a 32-bit wide synchronous memory and grants,
// frees or reserves ports of the range [range_start, range_end).
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on s_axis_* (mode in tuser, count and port in tdata, list end
//   in tlast). Results leave on m_axis_* through one output register; tlast
//   marks the last result of an item. The range is set through cfg_we_i /
//   cfg_idx_i / cfg_wdata_i while the block is idle.
// Timing:
//   Release and reserve of an in-range port read the row, then modify it,
//   write it back and load the result in S_MOD. Items answered without the
//   bitmap (zero count, too few free, out of range, skipped) load their
//   result at accept. Allocate loads the first row into the scan register
//   via S_LOAD, grants one port per cycle while the receiver takes results,
//   and steps over a full row by writing it back and rereading via S_LOAD.
// Reset and range writes:
//   Both start a clearing pass that zeroes the bitmap one row per cycle;
//   no item is accepted meanwhile.
// Stalls:
//   An item is accepted only when the output register is free or being
//   emptied; a stalled receiver holds S_MOD and each grant in S_SCAN.
// ----------------------------------------------------------------------------
module range_port_allocator #(
  parameter int PORTS     = 1024,
  parameter int MAX_GRANT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rpa_pkg::PORT_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rpa_pkg::S_DATA_W-1:0]  s_axis_tdata,  // count[6:0], port[22:7], zero pad
  input  logic [rpa_pkg::MODE_W-1:0]    s_axis_tuser,  // mode[1:0]
  input  logic                          s_axis_tlast,  // list_end
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rpa_pkg::M_DATA_W-1:0]  m_axis_tdata,  // granted_port[15:0],
                                                       // port_valid[16], status[18:17],
                                                       // free_count[29:19], zero pad
  output logic                          m_axis_tlast   // final_res
);
  import rpa_pkg::*;

  localparam int ROWS  = (PORTS + WORD_W - 1) / WORD_W;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FW    = $clog2(PORTS + 1);
  localparam int SPAN_W = PORT_W + 1;

  // Control and payload registers
  rpa_state_e               state_q, state_d;
  logic [PORT_W-1:0]        start_q, start_d;
  logic [PORT_W-1:0]        end_q, end_d;
  logic [FW-1:0]            free_q, free_d;
  logic                     abort_q, abort_d;
  logic [RW-1:0]            clr_q, clr_d;
  logic [RW-1:0]            row_q, row_d;
  logic [WORD_W-1:0]        word_q, word_d;
  logic [COUNT_W-1:0]       remain_q, remain_d;
  logic [MODE_W-1:0]        mode_q, mode_d;
  logic [PORT_W-1:0]        idx_q, idx_d;
  logic                     out_vld_q, out_vld_d;
  logic [PORT_W-1:0]        out_port_q, out_port_d;
  logic                     out_pv_q, out_pv_d;
  logic [STATUS_W-1:0]      out_st_q, out_st_d;
  logic                     out_fin_q, out_fin_d;
  logic [FREE_W-1:0]        out_free_q, out_free_d;

  // Bitmap memory
  logic [WORD_W-1:0]        map_mem_q [ROWS];
  logic [WORD_W-1:0]        rdata_q;
  logic                     mem_we, mem_re;
  logic [RW-1:0]            mem_waddr, mem_raddr;
  logic [WORD_W-1:0]        mem_wdata;

  // Decoded input fields
  logic [COUNT_W-1:0]       in_count;
  logic [PORT_W-1:0]        in_port;
  logic [PORT_W-1:0]        in_idx;
  logic                     in_rng;
  logic                     in_acc;
  logic                     out_free;

  // Range and scan helpers
  logic [SPAN_W-1:0]        diff_w, span_w, base_w;
  logic [WORD_W-1:0]        avail;
  logic                     found;
  logic [BIT_W-1:0]         sel;
  logic [BIT_W-1:0]         mod_bit;

  assign in_count = s_axis_tdata[COUNT_W-1:0];
  assign in_port  = s_axis_tdata[COUNT_W+PORT_W-1:COUNT_W];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Effective span, zero when the range is unusable
  assign diff_w = {1'b0, end_q} - {1'b0, start_q};
  always_comb begin
    if (end_q > start_q && diff_w >= SPAN_W'(MIN_SPAN) && diff_w <= SPAN_W'(PORTS)) begin
      span_w = diff_w;
    end else begin
      span_w = '0;
    end
  end

  // Range check of the incoming port
  assign in_idx = in_port - start_q;
  assign in_rng = (span_w != '0) && (in_port >= start_q) && ({1'b0, in_idx} < span_w);

  // Find the lowest free in-range bit of the held row
  assign base_w = SPAN_W'({row_q, {BIT_W{1'b0}}});
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int b = 0; b < WORD_W; b++) begin
      avail[b] = !word_q[b] && ((base_w + SPAN_W'(b)) < span_w);
    end
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found = 1'b1;
        sel   = BIT_W'(b);
      end
    end
  end

  assign mod_bit = idx_q[BIT_W-1:0];

  // Next state, memory controls and result loading
  always_comb begin
    state_d    = state_q;
    start_d    = start_q;
    end_d      = end_q;
    free_d     = free_q;
    abort_d    = abort_q;
    clr_d      = clr_q;
    row_d      = row_q;
    word_d     = word_q;
    remain_d   = remain_q;
    mode_d     = mode_q;
    idx_d      = idx_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_port_d = out_port_q;
    out_pv_d   = out_pv_q;
    out_st_d   = out_st_q;
    out_fin_d  = out_fin_q;
    out_free_d = out_free_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    case (state_q)
      // Zero the bitmap one row per cycle
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == RW'(ROWS - 1)) begin
          free_d  = FW'(span_w);
          state_d = S_IDLE;
        end
      end

      // Take an item; answer directly or start a row access
      S_IDLE: begin
        if (in_acc) begin
          mode_d = s_axis_tuser;
          idx_d  = in_idx;
          case (s_axis_tuser)
            MODE_ALLOC: begin
              if (in_count == '0) begin
                out_vld_d  = 1'b1;
                out_port_d = '0;
                out_pv_d   = 1'b0;
                out_st_d   = ST_OK;
                out_fin_d  = 1'b1;
                out_free_d = FREE_W'(free_q);
              end else if ({1'b0, in_count} > 8'(MAX_GRANT) ||
                           SPAN_W'(free_q) < SPAN_W'(in_count)) begin
                out_vld_d  = 1'b1;
                out_port_d = '0;
                out_pv_d   = 1'b0;
                out_st_d   = ST_FEW;
                out_fin_d  = 1'b1;
                out_free_d = FREE_W'(free_q);
              end else begin
                row_d     = '0;
                remain_d  = in_count;
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = S_LOAD;
              end
            end
            MODE_RELEASE: begin
              if (in_rng) begin
                mem_re    = 1'b1;
                mem_raddr = RW'(in_idx >> BIT_W);
                state_d   = S_MOD;
              end else begin
                out_vld_d  = 1'b1;
                out_port_d = '0;
                out_pv_d   = 1'b0;
                out_st_d   = ST_OK;
                out_fin_d  = 1'b1;
                out_free_d = FREE_W'(free_q);
              end
            end
            MODE_RESERVE: begin
              if (abort_q || !in_rng) begin
                out_vld_d  = 1'b1;
                out_port_d = '0;
                out_pv_d   = 1'b0;
                out_st_d   = abort_q ? ST_SKIP : ST_RANGE;
                out_fin_d  = 1'b1;
                out_free_d = FREE_W'(free_q);
                abort_d    = !s_axis_tlast;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = RW'(in_idx >> BIT_W);
                state_d   = S_MOD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Clear (release) or set (reserve) one bit of the read row, write it back and answer
      S_MOD: begin
        if (out_free) begin
          word_d = rdata_q;
          if (mode_q == MODE_RELEASE) begin
            if (rdata_q[mod_bit]) begin
              word_d[mod_bit] = 1'b0;
              free_d          = free_q + 1'b1;
            end
          end else begin
            if (!rdata_q[mod_bit]) begin
              word_d[mod_bit] = 1'b1;
              free_d          = free_q - 1'b1;
            end
          end
          mem_we     = 1'b1;
          mem_waddr  = RW'(idx_q >> BIT_W);
          mem_wdata  = word_d;
          out_vld_d  = 1'b1;
          out_port_d = '0;
          out_pv_d   = 1'b0;
          out_st_d   = ST_OK;
          out_fin_d  = 1'b1;
          out_free_d = FREE_W'(free_d);
          state_d    = S_IDLE;
        end
      end

      // Hold the freshly read row for scanning
      S_LOAD: begin
        word_d  = rdata_q;
        state_d = S_SCAN;
      end

      // Grant the lowest free bit, or write back and step to the next row
      S_SCAN: begin
        if (found) begin
          if (out_free) begin
            word_d[sel] = 1'b1;
            free_d      = free_q - 1'b1;
            remain_d    = remain_q - 1'b1;
            out_vld_d   = 1'b1;
            out_port_d  = start_q + PORT_W'(base_w) + PORT_W'(sel);
            out_pv_d    = 1'b1;
            out_st_d    = ST_OK;
            out_fin_d   = (remain_q == COUNT_W'(1));
            out_free_d  = FREE_W'(free_d);
            if (remain_q == COUNT_W'(1)) begin
              mem_we    = 1'b1;
              mem_waddr = row_q;
              mem_wdata = word_d;
              state_d   = S_IDLE;
            end
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = row_q;
          mem_wdata = word_q;
          row_d     = row_q + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = row_d;
          state_d   = S_LOAD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Range writes restart the clearing pass
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_START) begin
        start_d = cfg_wdata_i;
      end else begin
        end_d = cfg_wdata_i;
      end
      clr_d   = '0;
      abort_d = 1'b0;
      state_d = S_CLEAR;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      start_q   <= '0;
      end_q     <= '0;
      free_q    <= '0;
      abort_q   <= 1'b0;
      clr_q     <= '0;
      row_q     <= '0;
      remain_q  <= '0;
      mode_q    <= MODE_ALLOC;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      start_q   <= start_d;
      end_q     <= end_d;
      free_q    <= free_d;
      abort_q   <= abort_d;
      clr_q     <= clr_d;
      row_q     <= row_d;
      remain_q  <= remain_d;
      mode_q    <= mode_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    idx_q      <= idx_d;
    out_port_q <= out_port_d;
    out_pv_q   <= out_pv_d;
    out_st_q   <= out_st_d;
    out_fin_q  <= out_fin_d;
    out_free_q <= out_free_d;
  end

  // Bitmap memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem_q[mem_raddr];
    end
  end

  // Result channel
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_fin_q;
  assign m_axis_tdata  = {{(M_DATA_W - PORT_W - 1 - STATUS_W - FREE_W){1'b0}},
                          out_free_q, out_st_q, out_pv_q, out_port_q};

endmodule
